// File: hdl/med3_pkg.sv
package med3_pkg;

  localparam int MaxCols   = 1024;
  localparam int ColBits   = $clog2(MaxCols);
  localparam int SideBits  = ColBits + 1;
  localparam int ValueBits = 16;
  localparam int KeyBits   = ValueBits + 1;

  localparam logic [SideBits-1:0] SideReset = SideBits'(257);
  localparam logic [SideBits-1:0] SideMin   = SideBits'(2);
  localparam logic [SideBits-1:0] SideMax   = SideBits'(MaxCols);

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [KeyBits-1:0]   key_t;
  typedef key_t [8:0]           keys_t;

  typedef enum logic [2:0] {
    PICK_NINE = 3'b001,
    PICK_SIX  = 3'b010,
    PICK_FOUR = 3'b100
  } pick_e;

  // cells of the window that lie outside the grid
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } excl_t;

  // one pass of odd-even transposition, excluded keys carry a high flag bit
  function automatic keys_t oet_pass(keys_t k, logic odd);
    keys_t r;
    key_t  t;
    logic  sw;
    r = k;
    for (int i = 0; i < 8; i++) begin
      if (i[0] == odd) begin
        // the flag decides first, the value only between equal flags
        if (r[i][ValueBits] != r[i+1][ValueBits]) sw = r[i][ValueBits];
        else sw = r[i][ValueBits-1:0] > r[i+1][ValueBits-1:0];
        if (sw) begin
          t      = r[i];
          r[i]   = r[i+1];
          r[i+1] = t;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/med3_in_if.sv
interface med3_in_if;
  import med3_pkg::*;
  logic   valid;
  logic   ready;
  logic   func;
  value_t pixel_value;

  modport source (output valid, output func, output pixel_value, input ready);
  modport sink (input valid, input func, input pixel_value, output ready);
endinterface

// File: hdl/med3_out_if.sv
interface med3_out_if;
  import med3_pkg::*;
  logic                valid;
  logic                ready;
  value_t              median_value;
  logic [ColBits-1:0]  out_row;
  logic [ColBits-1:0]  out_col;
  logic                frame_last;

  modport source (output valid, output median_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input median_value, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// File: hdl/median_filter_3x3_grid.sv
// 3x3 median filter over a square grid streamed in raster order.
// in_ch carries one beat per pixel (func = 0) or a drain tick (func = 1).
// out_ch gives one beat per output pixel with its row, column and a
// frame_last flag on the final pixel of the grid.
// cfg_we_i / cfg_wdata_i set the grid side (clamped to 2..1024) and
// restart the frame; write only while the block is idle.
// Each output leaves grid_side + 1 accepted beats after its pixel came in;
// after the last pixel of a frame, grid_side + 1 drain ticks flush it out.
// Drain ticks sent while pixels are still expected are dropped.
// Registered steps from the edge that accepts a beat to its output beat
// being valid: line store read at that edge, then window shift with the
// first half of the sorting network, the second half, output pick.
// Throughput is one beat per cycle unless out_ch stalls, set by the single
// read and write port of each line store and the fully pipelined sorter.
// A stall on out_ch holds the whole pipeline and drops in_ch.ready.
// Reset sets the grid side to 257 and clears all counters and valid flags;
// the line stores are not cleared and need no clearing pass.
module median_filter_3x3_grid (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [med3_pkg::SideBits-1:0] cfg_wdata_i,
  med3_in_if.sink                 in_ch,
  med3_out_if.source              out_ch
);
  import med3_pkg::*;

  logic [SideBits-1:0] grid_q;
  logic [SideBits-1:0] side;
  logic [SideBits-1:0] in_row_q, in_row_d;
  logic [ColBits-1:0]  in_col_q, in_col_d;
  logic [ColBits-1:0]  out_row_q, out_row_d;
  logic [ColBits-1:0]  out_col_q, out_col_d;
  logic [SideBits-1:0] col_inc, ocol_inc;

  logic adv, accept, flushing, do_item, primed, last;
  excl_t excl;
  pick_e pick;

  value_t upper_mem [MaxCols];
  value_t lower_mem [MaxCols];
  value_t top_rd_q, mid_rd_q;
  logic   rd_en, wr_en;

  // stage 1
  logic               s1_v_q, s1_prim_q, s1_flush_q, s1_last_q;
  value_t             s1_pix_q;
  logic [ColBits-1:0] s1_addr_q, s1_row_q, s1_col_q;
  excl_t              s1_excl_q;
  pick_e              s1_pick_q;
  value_t [8:0]       win_q, win_d;
  keys_t              keys1, half1;

  // stage 2 and 3
  logic               s2_v_q, s2_last_q, s3_v_q, s3_last_q;
  keys_t              s2_keys_q, s3_keys_q, sort2;
  pick_e              s2_pick_q, s3_pick_q;
  logic [ColBits-1:0] s2_row_q, s2_col_q, s3_row_q, s3_col_q;

  // output
  logic               out_v_q, out_last_q;
  value_t             out_med_q, med_d;
  logic [ColBits-1:0] out_row_o_q, out_col_o_q;
  logic [ValueBits:0] sum6, sum4;

  always_comb begin
    side = grid_q;
    if (grid_q < SideMin) side = SideMin;
    if (grid_q > SideMax) side = SideMax;
  end

  assign adv         = !out_v_q || out_ch.ready;
  assign in_ch.ready = adv;
  assign flushing    = in_row_q >= side;
  assign do_item     = !(in_ch.func && !flushing);
  assign accept      = in_ch.valid && adv && do_item;
  assign primed      = (in_row_q >= SideBits'(2)) ||
                       (in_row_q == SideBits'(1) && in_col_q != '0);
  assign last        = ({1'b0, out_row_q} == side - SideBits'(1)) &&
                       ({1'b0, out_col_q} == side - SideBits'(1));

  assign excl.top   = out_row_q == '0;
  assign excl.bot   = {1'b0, out_row_q} + SideBits'(1) >= side;
  assign excl.left  = out_col_q == '0;
  assign excl.right = {1'b0, out_col_q} + SideBits'(1) >= side;

  always_comb begin
    priority if ((excl.top || excl.bot) && (excl.left || excl.right)) pick = PICK_FOUR;
    else if (excl.top || excl.bot || excl.left || excl.right) pick = PICK_SIX;
    else pick = PICK_NINE;
  end

  assign col_inc  = {1'b0, in_col_q} + SideBits'(1);
  assign ocol_inc = {1'b0, out_col_q} + SideBits'(1);

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (col_inc >= side) begin
      in_col_d = '0;
      in_row_d = in_row_q + SideBits'(1);
    end else begin
      in_col_d = col_inc[ColBits-1:0];
    end
    if (primed) begin
      if (last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
      end else if (ocol_inc >= side) begin
        out_col_d = '0;
        out_row_d = out_row_q + ColBits'(1);
      end else begin
        out_col_d = ocol_inc[ColBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q    <= SideReset;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_we_i) begin
      grid_q    <= cfg_wdata_i;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (accept) begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
    end
  end

  // line stores: read at accept, write back when a non-flush item leaves stage 1
  assign rd_en = accept;
  assign wr_en = adv && s1_v_q && !s1_flush_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) top_rd_q <= upper_mem[in_col_q];
    if (wr_en) upper_mem[s1_addr_q] <= mid_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) mid_rd_q <= lower_mem[in_col_q];
    if (wr_en) lower_mem[s1_addr_q] <= s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= accept;
      s2_v_q  <= s1_v_q && s1_prim_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q   <= in_ch.pixel_value;
      s1_flush_q <= flushing;
      s1_addr_q  <= in_col_q;
      s1_prim_q  <= primed;
      s1_row_q   <= out_row_q;
      s1_col_q   <= out_col_q;
      s1_last_q  <= last;
      s1_excl_q  <= excl;
      s1_pick_q  <= pick;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]   = win_q[i*3+1];
      win_d[i*3+1] = win_q[i*3+2];
    end
    win_d[2] = top_rd_q;
    win_d[5] = mid_rd_q;
    win_d[8] = s1_flush_q ? '0 : s1_pix_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        keys1[i*3+j] = {(i == 0 && s1_excl_q.top) || (i == 2 && s1_excl_q.bot) ||
                        (j == 0 && s1_excl_q.left) || (j == 2 && s1_excl_q.right),
                        win_d[i*3+j]};
      end
    end
    half1 = keys1;
    for (int p = 0; p < 5; p++) half1 = oet_pass(half1, p[0]);
    sort2 = s2_keys_q;
    for (int p = 5; p < 9; p++) sort2 = oet_pass(sort2, p[0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) win_q <= win_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_keys_q   <= half1;
      s2_pick_q   <= s1_pick_q;
      s2_row_q    <= s1_row_q;
      s2_col_q    <= s1_col_q;
      s2_last_q   <= s1_last_q;
      s3_keys_q   <= sort2;
      s3_pick_q   <= s2_pick_q;
      s3_row_q    <= s2_row_q;
      s3_col_q    <= s2_col_q;
      s3_last_q   <= s2_last_q;
      out_med_q   <= med_d;
      out_row_o_q <= s3_row_q;
      out_col_o_q <= s3_col_q;
      out_last_q  <= s3_last_q;
    end
  end

  assign sum6 = {1'b0, s3_keys_q[2][ValueBits-1:0]} + {1'b0, s3_keys_q[3][ValueBits-1:0]};
  assign sum4 = {1'b0, s3_keys_q[1][ValueBits-1:0]} + {1'b0, s3_keys_q[2][ValueBits-1:0]};

  always_comb begin
    unique case (s3_pick_q)
      PICK_NINE: med_d = s3_keys_q[4][ValueBits-1:0];
      PICK_SIX:  med_d = sum6[ValueBits:1];
      PICK_FOUR: med_d = sum4[ValueBits:1];
      default:   med_d = s3_keys_q[4][ValueBits-1:0];
    endcase
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.median_value = out_med_q;
  assign out_ch.out_row      = out_row_o_q;
  assign out_ch.out_col      = out_col_o_q;
  assign out_ch.frame_last   = out_last_q;

  // write-back never hits the entry being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en && wr_en |-> in_col_q != s1_addr_q)
    else $error("line store read and write collide");

  // the final pixel sits on the diagonal corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_last_q |-> out_row_o_q == out_col_o_q)
    else $error("frame_last off the corner");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, in_col_q} < side)
    else $error("input column beyond grid side");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_col_q} < side && {1'b0, out_row_q} < side)
    else $error("output position beyond grid side");

endmodule

// File: verif/median_filter_3x3_grid_test.sv
`timescale 1ns / 1ps

module median_filter_3x3_grid_test;
  import med3_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 12;
  localparam int RandomItems = 500;

  typedef struct packed {
    value_t             med;
    logic [ColBits-1:0] row;
    logic [ColBits-1:0] col;
    logic               last;
  } out_pix_t;

  class median_scoreboard;
    int        side;
    value_t    upper [MaxCols];
    value_t    lower [MaxCols];
    value_t    win [9];
    int        in_row, in_col, out_row, out_col;
    out_pix_t  pending_q[$];
    int        errors;

    function void clear_counters();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function void reset_state();
      side = 257;
      foreach (upper[i]) begin
        upper[i] = '0;
        lower[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      clear_counters();
      errors = 0;
    endfunction

    function void set_side(logic [SideBits-1:0] v);
      side = v;
      if (side < 2) side = 2;
      if (side > MaxCols) side = MaxCols;
      clear_counters();
    endfunction

    // median of the in-grid cells, mean of the middle pair for even counts
    function value_t window_median(int r, int c);
      int vals[$];
      int n;
      for (int i = 0; i < 3; i++) begin
        if ((i == 0 && r == 0) || (i == 2 && r + 1 >= side)) continue;
        for (int j = 0; j < 3; j++) begin
          if ((j == 0 && c == 0) || (j == 2 && c + 1 >= side)) continue;
          vals = {vals, int'(win[i*3+j])};
        end
      end
      vals.sort();
      n = vals.size();
      if (n % 2) return value_t'(vals[n/2]);
      return value_t'((vals[n/2-1] + vals[n/2]) >> 1);
    endfunction

    function void note_beat(logic f, value_t v);
      bit       flushing;
      bit       primed;
      value_t   top, mid;
      out_pix_t p;
      flushing = in_row >= side;
      if (!flushing && f) return;
      top = upper[in_col];
      mid = lower[in_col];
      if (!flushing) begin
        upper[in_col] = mid;
        lower[in_col] = v;
      end
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = flushing ? '0 : v;
      primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= side) begin
        in_col = 0;
        in_row++;
      end
      if (!primed) return;
      p.med = window_median(out_row, out_col);
      p.row = out_row;
      p.col = out_col;
      p.last = (out_row == side - 1 && out_col == side - 1);
      pending_q = {pending_q, p};
      if (p.last) begin
        clear_counters();
      end else begin
        out_col++;
        if (out_col >= side) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_beat(out_pix_t got);
      out_pix_t want;
      if (pending_q.size() == 0) begin
        if (errors < 10) $display("unexpected output beat: %p", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        if (errors < 10)
          $display("mismatch: expected med %h row %0d col %0d last %b,",
                   want.med, want.row, want.col, want.last,
                   " got med %h row %0d col %0d last %b",
                   got.med, got.row, got.col, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [SideBits-1:0] cfg_wdata;
  int                  idle_pct;
  int                  stall_pct;
  int                  quiet_cycles;
  int                  items_sent;
  median_scoreboard    sb;

  med3_in_if  in_ch ();
  med3_out_if out_ch ();

  median_filter_3x3_grid u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_side(cfg_wdata);
      if (in_ch.valid && in_ch.ready) sb.note_beat(in_ch.func, in_ch.pixel_value);
      if (out_ch.valid && out_ch.ready)
        sb.check_beat({out_ch.median_value, out_ch.out_row, out_ch.out_col, out_ch.frame_last});
    end
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[median_filter_3x3_grid] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(logic f, value_t v);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.pixel_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_side(logic [SideBits-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one frame of random pixels, with ignored drain noise, an optional cut
  // part way and an optional mid-frame pause until all pending outputs are out
  task automatic run_frame(int side, bit may_cut, bit pause);
    int n;
    int cut;
    n = side * side;
    cut = (may_cut && $urandom_range(99) < 15) ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < 10) send_beat(1'b1, value_t'($urandom));
      send_beat(1'b0, value_t'($urandom));
      items_sent++;
      if (pause && i == n / 2) begin
        in_ch.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
      end
    end
    if (cut == n) begin
      // flush beats, pixels here act as drain ticks
      for (int k = 0; k <= side; k++) begin
        send_beat(1'($urandom_range(1)), value_t'($urandom));
        items_sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    int side;
    int frame;
    sb = new();
    sb.reset_state();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.pixel_value = '0;
    out_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset side of 257: a few pixels that cannot complete anything
    for (int i = 0; i < 4; i++) send_beat(1'b0, value_t'($urandom));
    wait_idle();

    // corner-only grid with extreme values and a drain while pixels expected
    write_side(SideBits'(2));
    send_beat(1'b1, 16'h1234);
    send_beat(1'b0, 16'hffff);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'hffff);
    send_beat(1'b0, 16'h0000);
    send_beat(1'b1, '0);
    send_beat(1'b0, 16'h5555);
    send_beat(1'b1, '0);
    wait_idle();

    // side below range clamps to two
    write_side(SideBits'(1));
    send_beat(1'b0, 16'h0000);
    send_beat(1'b0, 16'hffff);
    send_beat(1'b0, 16'hffff);
    send_beat(1'b0, 16'hffff);
    for (int k = 0; k < 3; k++) send_beat(1'b1, '0);
    wait_idle();

    write_side(SideBits'(3));
    run_frame(3, 1'b0, 1'b1);

    // side above range, a few pixels that cannot complete anything
    write_side(SideBits'(2047));
    for (int i = 0; i < 4; i++) send_beat(1'b0, value_t'($urandom));
    wait_idle();
    write_side(SideBits'(0));
    run_frame(2, 1'b0, 1'b0);

    frame = 0;
    while (items_sent < RandomItems) begin
      case (frame % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      side = $urandom_range(2, 9);
      write_side(SideBits'(side));
      run_frame(side, 1'b1, (frame % 7) == 3);
      frame++;
    end

    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[median_filter_3x3_grid] OK");
    end else begin
      $display("[median_filter_3x3_grid] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/med3_pkg.sv
hdl/med3_in_if.sv
hdl/med3_out_if.sv
hdl/median_filter_3x3_grid.sv
verif/median_filter_3x3_grid_test.sv
